### design/u8sd_pkg.sv
`timescale 1ns / 1ps

package u8sd_pkg;

    // Fixed widths of the stream fields.
    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int LEN_W    = 3;
    localparam int IDX_W    = 16;
    localparam int TOTAL_W  = 17;
    localparam int TARGET_W = 16;

    // Output beat packing: code point, length, index, total, padded to bytes.
    localparam int OUT_FIELDS_W = CP_W + LEN_W + IDX_W + TOTAL_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 2;

    // Lead and continuation byte bounds used by the strict decoder.
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] LEAD3_SURR = 8'hED;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] E0_MIN     = 8'hA0;
    localparam logic [7:0] ED_LIMIT   = 8'hA0;
    localparam logic [7:0] F0_MIN     = 8'h90;
    localparam logic [7:0] F4_MAX     = 8'h8F;

    // Sequence state carried from byte to byte (the glyph counter lives
    // in the top level because its width follows a parameter).
    typedef struct packed {
        logic [1:0]      pending;
        logic [7:0]      lead;
        logic [CP_W-1:0] partial;
        logic [2:0]      seq_len;
        logic            err;
    } seq_state_t;

    // What one byte does: next sequence state plus the result to emit.
    typedef struct packed {
        seq_state_t       next;
        logic             emit;
        logic             malformed;
        logic             count_inc;
        logic             clear;
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] byte_length;
    } step_t;

endpackage

### design/u8sd_step.sv
`timescale 1ns / 1ps

module u8sd_step (
    input  u8sd_pkg::seq_state_t  state,
    input  logic [7:0]            data_byte,
    input  logic                  final_byte,
    input  logic                  overflow,
    output u8sd_pkg::step_t       step
);
    import u8sd_pkg::*;

    logic seq_error;

    // Decode one byte against the current sequence state.
    always_comb
    begin
        step             = '0;
        step.next        = state;
        seq_error        = 1'b0;

        if (state.err)
        begin
            // Bytes after an error are dropped; the final one reports again.
            if (final_byte)
            begin
                step.emit      = 1'b1;
                step.malformed = 1'b1;
                step.clear     = 1'b1;
            end
        end
        else
        begin
            if (state.pending == 2'd0)
            begin
                // Lead byte classification.
                case (data_byte) inside
                    [8'h00 : 8'h7F]:
                    begin
                        step.next.partial = CP_W'(data_byte);
                        step.next.seq_len = 3'd1;
                    end
                    [LEAD2_LO : LEAD2_HI]:
                    begin
                        step.next.partial = CP_W'(data_byte[4:0]);
                        step.next.seq_len = 3'd2;
                        step.next.pending = 2'd1;
                    end
                    [LEAD3_LO : LEAD3_HI]:
                    begin
                        step.next.partial = CP_W'(data_byte[3:0]);
                        step.next.seq_len = 3'd3;
                        step.next.pending = 2'd2;
                    end
                    [LEAD4_LO : LEAD4_HI]:
                    begin
                        step.next.partial = CP_W'(data_byte[2:0]);
                        step.next.seq_len = 3'd4;
                        step.next.pending = 2'd3;
                    end
                    default:
                    begin
                        seq_error = 1'b1;
                    end
                endcase
                step.next.lead = data_byte;
            end
            else
            begin
                // Continuation byte, with range checks on the second byte.
                if ((data_byte & CONT_MASK) != CONT_TAG)
                begin
                    seq_error = 1'b1;
                end
                else if (({1'b0, state.pending} + 3'd1) == state.seq_len)
                begin
                    if ((state.lead == LEAD3_LO && data_byte < E0_MIN) ||
                        (state.lead == LEAD3_SURR && data_byte >= ED_LIMIT) ||
                        (state.lead == LEAD4_LO && data_byte < F0_MIN) ||
                        (state.lead == LEAD4_HI && data_byte > F4_MAX))
                    begin
                        seq_error = 1'b1;
                    end
                end

                if (!seq_error)
                begin
                    step.next.partial = {state.partial[CP_W-7:0], data_byte[5:0]};
                    step.next.pending = state.pending - 2'd1;
                end
            end

            // Decide the result of this byte.
            if (seq_error || (step.next.pending != 2'd0 && final_byte) ||
                (step.next.pending == 2'd0 && overflow))
            begin
                step.emit      = 1'b1;
                step.malformed = 1'b1;
                if (final_byte)
                begin
                    step.clear = 1'b1;
                end
                else
                begin
                    step.next.err = 1'b1;
                end
            end
            else if (step.next.pending == 2'd0)
            begin
                step.emit        = 1'b1;
                step.count_inc   = 1'b1;
                step.code_point  = step.next.partial;
                step.byte_length = step.next.seq_len;
                step.clear       = final_byte;
                step.next.partial = '0;
                step.next.seq_len = 3'd0;
                step.next.lead    = 8'd0;
            end
        end
    end

endmodule

### design/utf8_strict_stream_decoder_core.sv
`timescale 1ns / 1ps

// Strict UTF-8 stream decoder: one input beat per byte, one result per glyph.
// A result is registered: it shows in the cycle after its byte is taken.
// Throughput: one byte per cycle while the output slot is free or draining;
// the output register decouples the two sides and the decode of a byte is
// one pass through the sequence-state logic. Reset (rst_n low, asynchronous)
// clears the sequence state, glyph count, target index and output valid flag.
module utf8_strict_stream_decoder_core #(
    parameter int INDEX_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: target_glyph.
    input  logic                                cfg_wr_en,
    input  logic [u8sd_pkg::TARGET_W-1:0]       cfg_wr_data,
    // Input beat. tdata: data_byte[7:0]. tlast: final_byte.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  logic                                s_tlast,
    // Output beat. tdata: code_point[20:0], byte_length[23:21],
    // glyph_index[39:24], total_glyphs[56:40], zero padding[63:57].
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [u8sd_pkg::OUT_DATA_W-1:0]     m_tdata,
    // tuser: selected[0], malformed[1]. tlast: end_of_string.
    output logic [u8sd_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tlast
);
    import u8sd_pkg::*;

    localparam int CNT_W = INDEX_BITS + 1;
    localparam int EXT_W = 33;
    localparam logic [EXT_W-1:0] IDX_MASK = (EXT_W'(1) << INDEX_BITS) - EXT_W'(1);

    seq_state_t             state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [TARGET_W-1:0]    target_reg;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_USER_W-1:0]  out_user_reg;
    logic                   out_last_reg;

    step_t                  step;
    logic                   accept;
    logic [CNT_W-1:0]       count_next;
    logic [EXT_W-1:0]       count_ext;
    logic [EXT_W-1:0]       idx_masked;
    logic [EXT_W-1:0]       total_ext;
    logic                   selected;
    logic [OUT_DATA_W-1:0]  out_data_next;

    // Byte decode.
    u8sd_step u_step (
        .state      (state_reg),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .overflow   (count_reg[INDEX_BITS]),
        .step       (step)
    );

    // Handshake: take a byte whenever the output slot is free or draining.
    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;

    // Result fields derived from the glyph counter.
    always_comb
    begin
        count_ext  = EXT_W'(count_reg);
        idx_masked = count_ext & IDX_MASK;
        total_ext  = step.count_inc ? (count_ext + EXT_W'(1)) : count_ext;
        selected   = step.count_inc && (idx_masked == EXT_W'(target_reg));
        count_next = step.clear ? '0 : (step.count_inc ? count_reg + CNT_W'(1) : count_reg);
        out_data_next = OUT_DATA_W'({total_ext[TOTAL_W-1:0], idx_masked[IDX_W-1:0],
                                     step.byte_length, step.code_point});
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            target_reg <= cfg_wr_data;
        end
    end

    // Sequence state and glyph counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= step.clear ? '0 : step.next;
            count_reg <= count_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= step.emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (accept && step.emit)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= {step.malformed, selected};
            out_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

### dv/utf8_strict_stream_decoder_core_test.sv
`timescale 1ns / 1ps

module utf8_strict_stream_decoder_core_test;

    import u8sd_pkg::*;

    // Bit positions of the result fields inside the output tdata.
    localparam int CP_LSB    = 0;
    localparam int LEN_LSB   = CP_W;
    localparam int IDX_LSB   = CP_W + LEN_W;
    localparam int TOTAL_LSB = CP_W + LEN_W + IDX_W;
    localparam int IDX_LIMIT = (1 << IDX_W) - 1;
    localparam int MAX_PRINTED = 30;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef struct {
        logic [CP_W-1:0]    code_point;
        logic [LEN_W-1:0]   byte_length;
        logic [IDX_W-1:0]   glyph_index;
        logic               selected;
        logic               malformed;
        logic               end_of_string;
        logic [TOTAL_W-1:0] total_glyphs;
    } glyph_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [TARGET_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic m_tlast;

    // Bytes waiting to be sent and results the decoder still owes.
    stream_byte_t  bytes_to_send[$];
    glyph_result_t results_due[$];
    logic [7:0]    str_bytes[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic rx_hold = 1'b0;
    logic rx_hold_go = 1'b0;
    int n_queued = 0;
    int n_sent = 0;
    int mismatches = 0;
    int n_glyphs = 0;
    int n_errors = 0;
    int n_selected = 0;
    int n_strings = 0;

    // Shadow copy of the decoder state and the target register.
    logic [1:0]          dec_pending;
    logic [7:0]          dec_lead;
    logic [CP_W-1:0]     dec_partial;
    logic [2:0]          dec_len;
    int                  dec_count;
    logic                dec_err_seen;
    logic [TARGET_W-1:0] sel_target;

    utf8_strict_stream_decoder_core #(
        .INDEX_BITS(IDX_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_string();
        dec_pending = '0;
        dec_lead = '0;
        dec_partial = '0;
        dec_len = '0;
        dec_count = 0;
        dec_err_seen = 1'b0;
    endtask

    // An error result carries the count of valid glyphs reached so far.
    task automatic flag_error(input logic last);
        glyph_result_t r;
        r.code_point = '0;
        r.byte_length = '0;
        r.glyph_index = dec_count[IDX_W-1:0];
        r.selected = 1'b0;
        r.malformed = 1'b1;
        r.end_of_string = last;
        r.total_glyphs = dec_count[TOTAL_W-1:0];
        results_due.push_back(r);
        if (last)
            clear_string();
        else
            dec_err_seen = 1'b1;
    endtask

    // Strict UTF-8 decode of one accepted byte; queues the result it causes.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        glyph_result_t r;
        if (dec_err_seen)
        begin
            if (last)
                flag_error(1'b1);
            return;
        end
        if (dec_pending == 0)
        begin
            if (b < CONT_TAG)
            begin
                dec_partial = {13'd0, b};
                dec_len = 3'd1;
            end
            else if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                dec_partial = {16'd0, b[4:0]};
                dec_len = 3'd2;
                dec_pending = 2'd1;
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                dec_partial = {17'd0, b[3:0]};
                dec_len = 3'd3;
                dec_pending = 2'd2;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                dec_partial = {18'd0, b[2:0]};
                dec_len = 3'd4;
                dec_pending = 2'd3;
            end
            else
            begin
                flag_error(last);
                return;
            end
            dec_lead = b;
        end
        else
        begin
            if ((b & CONT_MASK) != CONT_TAG)
            begin
                flag_error(last);
                return;
            end
            // The second byte also rules out overlongs, surrogates and
            // values above the last plane.
            if (dec_pending + 1 == dec_len)
            begin
                if ((dec_lead == LEAD3_LO && b < E0_MIN) ||
                    (dec_lead == LEAD3_SURR && b >= ED_LIMIT) ||
                    (dec_lead == LEAD4_LO && b < F0_MIN) ||
                    (dec_lead == LEAD4_HI && b > F4_MAX))
                begin
                    flag_error(last);
                    return;
                end
            end
            dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
            dec_pending = dec_pending - 2'd1;
        end
        if (dec_pending != 0)
        begin
            if (last)
                flag_error(1'b1);
            return;
        end
        if (dec_count > IDX_LIMIT)
        begin
            flag_error(last);
            return;
        end
        r.code_point = dec_partial;
        r.byte_length = dec_len;
        r.glyph_index = dec_count[IDX_W-1:0];
        r.selected = (dec_count == sel_target);
        r.malformed = 1'b0;
        r.end_of_string = last;
        r.total_glyphs = dec_count[TOTAL_W-1:0] + 1'b1;
        results_due.push_back(r);
        dec_count++;
        if (last)
            clear_string();
        else
        begin
            dec_partial = '0;
            dec_len = '0;
            dec_lead = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (mismatches < MAX_PRINTED)
            $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endtask

    task automatic push_item(input logic [7:0] data, input logic last);
        stream_byte_t item;
        item.data = data;
        item.last = last;
        bytes_to_send.push_back(item);
        n_queued++;
    endtask

    // Sends the scratch string, with tlast on its final byte.
    task automatic push_string();
        for (int i = 0; i < str_bytes.size(); i++)
            push_item(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    // Appends one well-formed glyph, often at a range boundary.
    task automatic append_glyph();
        logic [CP_W-1:0] cp;
        int len;
        int pick;
        len = $urandom_range(1, 4);
        pick = $urandom_range(0, 5);
        case (len)
            1: cp = (pick == 0) ? 21'h0 : (pick == 1) ? 21'h7F
                                        : CP_W'($urandom_range(0, 'h7F));
            2: cp = (pick == 0) ? 21'h80 : (pick == 1) ? 21'h7FF
                                         : CP_W'($urandom_range('h80, 'h7FF));
            3:
            begin
                case (pick)
                    0: cp = 21'h800;
                    1: cp = 21'hFFFF;
                    2: cp = 21'hD7FF;
                    3: cp = 21'hE000;
                    default:
                    begin
                        cp = CP_W'($urandom_range('h800, 'hFFFF));
                        if (cp >= 21'hD800 && cp <= 21'hDFFF)
                            cp = cp ^ 21'h2000;
                    end
                endcase
            end
            default: cp = (pick == 0) ? 21'h10000 : (pick == 1) ? 21'h10FFFF
                                             : CP_W'($urandom_range('h10000, 'h10FFFF));
        endcase
        case (len)
            1: str_bytes.push_back(cp[7:0]);
            2:
            begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back({2'b10, cp[17:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Mostly well-formed strings; the rest are corrupted, cut short or noise.
    task automatic add_random_string();
        int n;
        int roll;
        int pos;
        str_bytes.delete();
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
            append_glyph();
        roll = $urandom_range(0, 99);
        pos = $urandom_range(0, str_bytes.size() - 1);
        if (roll < 8)
            str_bytes[pos] = 8'($urandom_range(0, 255));
        else if (roll < 13)
            str_bytes.insert(pos, 8'($urandom_range(0, 255)));
        else if (roll < 17 && str_bytes.size() > 1)
            void'(str_bytes.pop_back());
        else if (roll < 21)
        begin
            str_bytes.delete();
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                str_bytes.push_back(8'($urandom_range(0, 255)));
        end
        push_string();
    endtask

    task automatic add_random_part(input int count);
        int goal;
        goal = n_queued + count;
        while (n_queued < goal)
            add_random_string();
    endtask

    // Waits until every queued byte went in and every result came out.
    task automatic wait_drained();
        while (bytes_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_target(input logic [TARGET_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sel_target = value;
    endtask

    // Input driver: a beat is taken when tvalid and tready meet at an edge.
    always @(posedge clk)
    begin
        stream_byte_t item;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tlast);
                n_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (bytes_to_send.size() == 0 || $urandom_range(0, 99) < tx_idle_pct)
                    s_tvalid <= 1'b0;
                else
                begin
                    item = bytes_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= item.data;
                    s_tlast <= item.last;
                end
            end
        end
    end

    // Output monitor: checks each result beat against the oldest one due.
    always @(posedge clk)
    begin
        glyph_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result with none due", '0, m_tdata);
                else
                begin
                    want = results_due.pop_front();
                    check_field("code_point", 64'(want.code_point),
                                64'(m_tdata[CP_LSB +: CP_W]));
                    check_field("byte_length", 64'(want.byte_length),
                                64'(m_tdata[LEN_LSB +: LEN_W]));
                    check_field("glyph_index", 64'(want.glyph_index),
                                64'(m_tdata[IDX_LSB +: IDX_W]));
                    check_field("total_glyphs", 64'(want.total_glyphs),
                                64'(m_tdata[TOTAL_LSB +: TOTAL_W]));
                    check_field("tdata padding", '0,
                                64'(m_tdata[OUT_DATA_W-1:OUT_FIELDS_W]));
                    check_field("selected", 64'(want.selected), 64'(m_tuser[0]));
                    check_field("malformed", 64'(want.malformed), 64'(m_tuser[1]));
                    check_field("end_of_string", 64'(want.end_of_string),
                                64'(m_tlast));
                    if (want.malformed)
                        n_errors++;
                    else
                        n_glyphs++;
                    if (want.selected)
                        n_selected++;
                    if (want.end_of_string)
                        n_strings++;
                end
            end
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // One long receiver stall, so the output fills and the input backs up.
    initial
    begin
        wait (rx_hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Stimulus and phase sequencing.
    initial
    begin
        clear_string();
        sel_target = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_target(16'd0);

        // Directed strings: every glyph length with extreme code points,
        // then each rejection rule, truncation and recovery after an error.
        tx_idle_pct = 18;
        rx_idle_pct = 66;
        str_bytes = '{8'h00, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80,
                      8'hF4, 8'h8F, 8'hBF, 8'hBF};
        push_string();
        str_bytes = '{8'hED, 8'hA0};
        push_string();
        str_bytes = '{8'h80, 8'h41, 8'h7F};
        push_string();
        str_bytes = '{8'hE0, 8'h9F};
        push_string();
        str_bytes = '{8'hF0, 8'h8F};
        push_string();
        str_bytes = '{8'hF4, 8'h90};
        push_string();
        str_bytes = '{8'hC2, 8'h41};
        push_string();
        str_bytes = '{8'hE2, 8'h82};
        push_string();
        str_bytes = '{8'hFF};
        push_string();
        wait_drained();

        // Random strings with a sender that rarely idles.
        write_target(16'd1);
        add_random_part(200);
        // The sender stops in the middle of a glyph until all is drained.
        push_item(8'hF0, 1'b0);
        push_item(8'h9F, 1'b0);
        wait_drained();
        push_item(8'h98, 1'b0);
        push_item(8'h80, 1'b1);
        wait_drained();

        // Random strings with a receiver that rarely idles.
        write_target(16'd4);
        tx_idle_pct = 66;
        rx_idle_pct = 18;
        add_random_part(200);
        wait_drained();

        // No idling, with a long output stall while bytes keep coming.
        write_target(16'd2);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_go = 1'b1;
        add_random_part(200);
        wait_drained();

        repeat (10) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch("results never delivered", 64'(results_due.size()), '0);
        $display("Sent %0d bytes in %0d strings; checked %0d glyphs (%0d selected)",
                 n_sent, n_strings, n_glyphs, n_selected);
        $display("and %0d malformed results, across four targets %s",
                 n_errors, "and a long output stall.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
